// File: hdl/lru_cache_access_cost_defines.svh
// assertion macros used by the cache top level
`ifndef LRU_CACHE_ACCESS_COST_DEFINES_SVH
`define LRU_CACHE_ACCESS_COST_DEFINES_SVH

// clocked check, masked while reset is applied
`define LCAC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lcac assertion failed");

// clocked check that also holds during reset
`define LCAC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lcac assertion failed");

`endif

// File: hdl/lcac_pkg.sv
// shared types and constants for the lru cache with access cost tally
package lcac_pkg;

    localparam int KEY_W   = 64;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 6;

    localparam logic [STAMP_W-1:0] HIT_COST  = 32'd1;
    localparam logic [STAMP_W-1:0] MISS_COST = 32'd5;

    // search carry handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               found;
        logic               free_found;
        logic               old_found;
        logic [STAMP_W-1:0] old_stamp;
    } carry_t;

    // entry write broadcast to all cells
    typedef struct packed {
        logic               en;
        logic               set_tag;
        logic [STAMP_W-1:0] stamp;
    } wr_t;

endpackage

// File: hdl/lru_cache_access_cost.sv
// top level: fully associative lru cache with access cost tally over a row of entry cells
// Each accepted key (letters folded to upper case, only the top KEY_CHARS bytes used) is
// looked up in a row of CAPACITY entry cells. A search wave enters the first cell in the cycle
// after acceptance and moves one cell per cycle, collecting the first hit, the lowest free
// entry and the oldest valid entry. After it leaves the last cell the outcome is latched;
// once the output register is free, the block updates the total (hit adds 1, miss adds 5,
// saturating), writes the chosen entry and returns ready. A new key is accepted only after
// the last one has passed through the cell row and been committed. The result is held in
// an output register, and the next key is accepted while it waits; the update of a later
// key waits until that register is free, which adds the cycles the receiver holds off.
// cache_size of zero makes every access miss and leaves the entries untouched; a value above
// CAPACITY acts as CAPACITY. Write cache_size only while no transaction is in flight.
module lru_cache_access_cost #(
    parameter int CAPACITY  = 32,
    parameter int KEY_CHARS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write: cache_size
    input  logic                         cfg_we,
    input  logic [lcac_pkg::CFG_W-1:0]   cfg_wdata,
    // key input
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,   // [63:0] city_key
    // result output
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata    // [0] hit, [32:1] total_time, [39:33] zero
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = (CNT_W > lcac_pkg::CFG_W) ? CNT_W : lcac_pkg::CFG_W;
    localparam int KEEP_LO = 8 - KEY_CHARS;
    localparam int SW     = lcac_pkg::STAMP_W;

    // control states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [lcac_pkg::CFG_W-1:0] cache_size_reg;
    logic [CNT_W-1:0]           entry_count_reg;
    logic [SW-1:0]              total_reg;
    logic                       launch_reg;

    logic [lcac_pkg::KEY_W-1:0] key_reg;
    logic [lcac_pkg::KEY_W-1:0] key_fold;

    // captured search outcome
    logic             fnd_reg;
    logic             free_reg;
    logic             old_reg;
    logic [IDX_W-1:0] fnd_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] old_idx_reg;

    logic          m_valid_reg;
    logic          m_hit_reg;
    logic [SW-1:0] m_total_reg;

    // cell row wiring, element 0 is the wave source
    lcac_pkg::carry_t chain_c    [0:CAPACITY];
    logic [IDX_W-1:0] chain_fidx [0:CAPACITY];
    logic [IDX_W-1:0] chain_ridx [0:CAPACITY];
    logic [IDX_W-1:0] chain_oidx [0:CAPACITY];

    lcac_pkg::wr_t    wr;
    logic [IDX_W-1:0] wr_idx;

    logic             accept;
    logic             scan_done;
    logic             commit;
    logic [LIM_W-1:0] limit;
    logic             lim_on;
    logic             is_hit;
    logic             use_free;
    logic [SW:0]      sum;
    logic [SW-1:0]    total_new;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign scan_done = (state_reg == ST_SCAN) && chain_c[CAPACITY].active;
    assign commit    = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // upper-case folding, bytes below the key length are dropped
    always_comb
    begin
        logic [7:0] ch;
        key_fold = '0;
        for (int b = 0; b < 8; b++)
        begin
            ch = s_tdata[8*b +: 8];
            if (b >= KEEP_LO)
            begin
                if ((ch >= 8'h61) && (ch <= 8'h7a))
                begin
                    key_fold[8*b +: 8] = ch - 8'h20;
                end
                else
                begin
                    key_fold[8*b +: 8] = ch;
                end
            end
        end
    end

    // effective size, clipped to the cell count
    always_comb
    begin
        if (LIM_W'(cache_size_reg) > LIM_W'(CAPACITY))
        begin
            limit = LIM_W'(CAPACITY);
        end
        else
        begin
            limit = LIM_W'(cache_size_reg);
        end
    end

    assign lim_on   = (limit != '0);
    assign is_hit   = lim_on && fnd_reg;
    assign use_free = (LIM_W'(entry_count_reg) < limit) && free_reg;

    // saturating running total
    assign sum       = {1'b0, total_reg} + {1'b0, (is_hit ? lcac_pkg::HIT_COST
                                                          : lcac_pkg::MISS_COST)};
    assign total_new = sum[SW] ? {SW{1'b1}} : sum[SW-1:0];

    // entry write: restamp on hit, fill or replace on miss
    always_comb
    begin
        wr.en      = commit && (is_hit || (lim_on && (use_free || old_reg)));
        wr.set_tag = !is_hit;
        wr.stamp   = total_new;
        if (is_hit)
        begin
            wr_idx = fnd_idx_reg;
        end
        else if (use_free)
        begin
            wr_idx = free_idx_reg;
        end
        else
        begin
            wr_idx = old_idx_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cache_size_reg  <= '0;
            entry_count_reg <= '0;
            total_reg       <= '0;
            launch_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept;
            if (cfg_we)
            begin
                cache_size_reg <= cfg_wdata;
            end
            if (commit)
            begin
                total_reg   <= total_new;
                m_valid_reg <= 1'b1;
                if (!is_hit && lim_on && use_free)
                begin
                    entry_count_reg <= entry_count_reg + CNT_W'(1);
                end
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= key_fold;
        end
        if (scan_done)
        begin
            fnd_reg      <= chain_c[CAPACITY].found;
            free_reg     <= chain_c[CAPACITY].free_found;
            old_reg      <= chain_c[CAPACITY].old_found;
            fnd_idx_reg  <= chain_fidx[CAPACITY];
            free_idx_reg <= chain_ridx[CAPACITY];
            old_idx_reg  <= chain_oidx[CAPACITY];
        end
        if (commit)
        begin
            m_hit_reg   <= is_hit;
            m_total_reg <= total_new;
        end
    end

    // wave source
    always_comb
    begin
        chain_c[0]        = '0;
        chain_c[0].active = launch_reg;
        chain_fidx[0]     = '0;
        chain_ridx[0]     = '0;
        chain_oidx[0]     = '0;
    end

    // row of entry cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lcac_cell #(
            .IDX_W  (IDX_W),
            .MY_IDX (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .key            (key_reg),
            .cin            (chain_c[i]),
            .cin_found_idx  (chain_fidx[i]),
            .cin_free_idx   (chain_ridx[i]),
            .cin_old_idx    (chain_oidx[i]),
            .cout           (chain_c[i+1]),
            .cout_found_idx (chain_fidx[i+1]),
            .cout_free_idx  (chain_ridx[i+1]),
            .cout_old_idx   (chain_oidx[i+1]),
            .wr             (wr),
            .wr_idx         (wr_idx)
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_total_reg, m_hit_reg};

    `include "lru_cache_access_cost_defines.svh"

    // an accepted key always launches a wave into the first cell
    `LCAC_ASSERT(a_launch, accept |=> launch_reg)
    // the wave only leaves the row while a search is in progress
    `LCAC_ASSERT(a_wave_scan, chain_c[CAPACITY].active |-> (state_reg == ST_SCAN))
    // a committed update always presents its result
    `LCAC_ASSERT(a_commit_out, commit |=> m_valid_reg)
    // fill count never passes the number of cells
    `LCAC_ASSERT_ALWAYS(a_count_max, entry_count_reg <= CNT_W'(CAPACITY))

endmodule

// File: hdl/lcac_cell.sv
// one cache entry cell: stores tag and stamp, folds its entry into the search carry
module lcac_cell #(
    parameter int IDX_W  = 5,
    parameter int MY_IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lcac_pkg::KEY_W-1:0]  key,
    input  lcac_pkg::carry_t            cin,
    input  logic [IDX_W-1:0]            cin_found_idx,
    input  logic [IDX_W-1:0]            cin_free_idx,
    input  logic [IDX_W-1:0]            cin_old_idx,
    output lcac_pkg::carry_t            cout,
    output logic [IDX_W-1:0]            cout_found_idx,
    output logic [IDX_W-1:0]            cout_free_idx,
    output logic [IDX_W-1:0]            cout_old_idx,
    input  lcac_pkg::wr_t               wr,
    input  logic [IDX_W-1:0]            wr_idx
);

    localparam logic [IDX_W-1:0] SELF = IDX_W'(MY_IDX);

    logic                          valid_reg;
    logic [lcac_pkg::KEY_W-1:0]    tag_reg;
    logic [lcac_pkg::STAMP_W-1:0]  stamp_reg;

    lcac_pkg::carry_t  carry_reg;
    lcac_pkg::carry_t  carry_next;
    logic [IDX_W-1:0]  found_idx_reg;
    logic [IDX_W-1:0]  found_idx_next;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [IDX_W-1:0]  free_idx_next;
    logic [IDX_W-1:0]  old_idx_reg;
    logic [IDX_W-1:0]  old_idx_next;

    logic wr_here;

    assign wr_here = wr.en && (wr_idx == SELF);

    always_comb
    begin
        carry_next     = cin;
        found_idx_next = cin_found_idx;
        free_idx_next  = cin_free_idx;
        old_idx_next   = cin_old_idx;
        // first matching entry wins
        if (!cin.found && valid_reg && (tag_reg == key))
        begin
            carry_next.found = 1'b1;
            found_idx_next   = SELF;
        end
        // lowest free entry
        if (!cin.free_found && !valid_reg)
        begin
            carry_next.free_found = 1'b1;
            free_idx_next         = SELF;
        end
        // strictly older only, so ties keep the lower index
        if (valid_reg && (!cin.old_found || (stamp_reg < cin.old_stamp)))
        begin
            carry_next.old_found = 1'b1;
            carry_next.old_stamp = stamp_reg;
            old_idx_next         = SELF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (wr_here)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
        if (wr_here)
        begin
            stamp_reg <= wr.stamp;
            if (wr.set_tag)
            begin
                tag_reg <= key;
            end
        end
    end

    assign cout           = carry_reg;
    assign cout_found_idx = found_idx_reg;
    assign cout_free_idx  = free_idx_reg;
    assign cout_old_idx   = old_idx_reg;

endmodule
